// ----- rtl/rmm_pkg.sv -----
// ----------------------------------------------------------------------------
// rmm_pkg: shared types for the range min/max segment tree
// Sequencer states and the control/status groups between top and engine.
// ----------------------------------------------------------------------------
package rmm_pkg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD_LEAF,
        S_UPD_RD,
        S_UPD_WR,
        S_QRY_L,
        S_QRY_R,
        S_DONE
    } t_state;

    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    typedef struct packed {
        logic start;     // beat accepted on the input side
        logic clear;     // leaf count written: restart the clearing pass
        logic out_free;  // output register can take a result this cycle
    } t_eng_ctl;

    typedef struct packed {
        logic ready;     // engine idle, can take a command
        logic done;      // result held on the result outputs
    } t_eng_sts;

endpackage

// ----- rtl/rmm_engine.sv -----
// ----------------------------------------------------------------------------
// rmm_engine: tree walker with node memory and one shared min/max unit
// Clears the node memory, runs point updates bottom-up and range queries
// by walking both bounds toward the root, one node access per cycle.
// ----------------------------------------------------------------------------
module rmm_engine #(
    parameter int MAX_LEAVES  = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rmm_pkg::t_eng_ctl                    i_ctl,
    output rmm_pkg::t_eng_sts                    o_sts,
    input  logic                                 i_action,
    input  logic [$clog2(MAX_LEAVES)-1:0]        i_left,
    input  logic [$clog2(MAX_LEAVES)-1:0]        i_right,
    input  logic signed [VALUE_WIDTH-1:0]        i_value_min,
    input  logic signed [VALUE_WIDTH-1:0]        i_value_max,
    input  logic [$clog2(MAX_LEAVES+1)-1:0]      i_leaf_count,
    output logic signed [VALUE_WIDTH-1:0]        o_result_min,
    output logic signed [VALUE_WIDTH-1:0]        o_result_max,
    output logic                                 o_index_error
);
    import rmm_pkg::*;

    localparam int LW    = $clog2(MAX_LEAVES + 1);
    localparam int DEPTH = 2 * MAX_LEAVES;
    localparam int NW    = $clog2(DEPTH);
    localparam int VW    = VALUE_WIDTH;
    localparam logic [VW-1:0] MIN_ID = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] MAX_ID = {1'b1, {(VW-1){1'b0}}};
    localparam logic [NW-1:0] ROOT   = NW'(1);
    localparam logic [NW-1:0] LAST   = NW'(DEPTH - 1);

    t_state r_state, n_state;

    logic [NW-1:0]   r_clr_cnt, n_clr_cnt;
    logic            r_action, n_action;
    logic            r_err, n_err;
    logic [NW-1:0]   r_cur, n_cur;       // update node, or left query bound
    logic [NW-1:0]   r_rnode, n_rnode;   // right query bound
    logic [VW-1:0]   r_acc_min, n_acc_min;
    logic [VW-1:0]   r_acc_max, n_acc_max;
    logic            r_pend, n_pend;     // read data waits to be folded in

    logic [2*VW-1:0] r_mem [DEPTH];
    logic [2*VW-1:0] r_rd_data;

    logic            mem_we;
    logic [NW-1:0]   mem_wa;
    logic [2*VW-1:0] mem_wd;
    logic            rd_en;
    logic [NW-1:0]   rd_addr;

    logic [VW-1:0]   rd_min, rd_max;
    logic [VW-1:0]   cmb_min, cmb_max;
    logic            start_err;
    logic [NW-1:0]   leaf_l, leaf_r;
    logic [NW:0]     l_inc;
    logic [NW-1:0]   r_decr;
    logic            l_take;
    logic            clr_last;

    // shared min/max unit: accumulator against the node just read
    assign rd_min  = r_rd_data[VW-1:0];
    assign rd_max  = r_rd_data[2*VW-1:VW];
    assign cmb_min = ($signed(rd_min) < $signed(r_acc_min)) ? rd_min : r_acc_min;
    assign cmb_max = ($signed(rd_max) > $signed(r_acc_max)) ? rd_max : r_acc_max;

    assign start_err = (LW'(i_left) >= i_leaf_count) ||
                       ((i_action == ACT_QUERY) && (LW'(i_right) >= i_leaf_count));
    assign leaf_l    = NW'(i_left) + NW'(i_leaf_count);
    assign leaf_r    = NW'(i_right) + NW'(i_leaf_count);
    assign l_inc     = {1'b0, r_cur} + (NW+1)'(r_cur[0]);
    assign r_decr    = r_rnode - NW'(!r_rnode[0]);
    assign l_take    = (r_cur <= r_rnode) && r_cur[0];
    assign clr_last  = (r_clr_cnt == LAST);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:    n_state = clr_last ? S_IDLE : S_CLEAR;
            S_IDLE: begin
                if (i_ctl.start) begin
                    if (start_err) begin
                        n_state = S_DONE;
                    end else if (i_action == ACT_UPDATE) begin
                        n_state = S_UPD_LEAF;
                    end else begin
                        n_state = S_QRY_L;
                    end
                end
            end
            S_UPD_LEAF: n_state = (r_cur == ROOT) ? S_DONE : S_UPD_RD;
            S_UPD_RD:   n_state = S_UPD_WR;
            S_UPD_WR:   n_state = ((r_cur >> 1) == ROOT) ? S_DONE : S_UPD_RD;
            S_QRY_L:    n_state = (r_cur > r_rnode) ? S_DONE : S_QRY_R;
            S_QRY_R:    n_state = S_QRY_L;
            S_DONE:     n_state = i_ctl.out_free ? S_IDLE : S_DONE;
            default:    n_state = S_CLEAR;
        endcase
        if (i_ctl.clear) begin
            n_state = S_CLEAR;
        end
    end

    // memory port and status outputs
    always_comb begin
        mem_we  = 1'b0;
        mem_wa  = r_cur;
        mem_wd  = {r_acc_max, r_acc_min};
        rd_en   = 1'b0;
        rd_addr = r_cur;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr_cnt;
                mem_wd = {MAX_ID, MIN_ID};
            end
            S_UPD_LEAF: begin
                mem_we = 1'b1;
            end
            S_UPD_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_cur ^ ROOT;
            end
            S_UPD_WR: begin
                mem_we = 1'b1;
                mem_wa = r_cur >> 1;
                mem_wd = {cmb_max, cmb_min};
            end
            S_QRY_L: begin
                rd_en = l_take;
            end
            S_QRY_R: begin
                rd_en   = !r_rnode[0];
                rd_addr = r_rnode;
            end
            S_IDLE, S_DONE: begin
                mem_we = 1'b0;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign o_sts.ready = (r_state == S_IDLE);
    assign o_sts.done  = (r_state == S_DONE);

    assign o_result_min  = ((r_action == ACT_QUERY) && !r_err) ? r_acc_min : '0;
    assign o_result_max  = ((r_action == ACT_QUERY) && !r_err) ? r_acc_max : '0;
    assign o_index_error = r_err;

    // walk registers
    always_comb begin
        n_clr_cnt = r_clr_cnt;
        n_action  = r_action;
        n_err     = r_err;
        n_cur     = r_cur;
        n_rnode   = r_rnode;
        n_acc_min = r_acc_min;
        n_acc_max = r_acc_max;
        n_pend    = r_pend;
        case (r_state)
            S_CLEAR: begin
                n_clr_cnt = clr_last ? '0 : r_clr_cnt + NW'(1);
            end
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_action = i_action;
                    n_err    = start_err;
                    n_cur    = leaf_l;
                    n_rnode  = leaf_r;
                    n_pend   = 1'b0;
                    if (i_action == ACT_UPDATE) begin
                        n_acc_min = i_value_min;
                        n_acc_max = i_value_max;
                    end else begin
                        n_acc_min = MIN_ID;
                        n_acc_max = MAX_ID;
                    end
                end
            end
            S_UPD_WR: begin
                n_acc_min = cmb_min;
                n_acc_max = cmb_max;
                n_cur     = r_cur >> 1;
            end
            S_QRY_L: begin
                if (r_pend) begin
                    n_acc_min = cmb_min;
                    n_acc_max = cmb_max;
                end
                n_pend = l_take;
            end
            S_QRY_R: begin
                if (r_pend) begin
                    n_acc_min = cmb_min;
                    n_acc_max = cmb_max;
                end
                n_pend  = !r_rnode[0];
                n_cur   = l_inc[NW:1];
                n_rnode = r_decr >> 1;
            end
            default: begin
                n_pend = r_pend;
            end
        endcase
        if (i_ctl.clear) begin
            n_clr_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
            r_pend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_pend    <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action  <= n_action;
        r_err     <= n_err;
        r_cur     <= n_cur;
        r_rnode   <= n_rnode;
        r_acc_min <= n_acc_min;
        r_acc_max <= n_acc_max;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

`ifndef SYNTH
    a_no_node0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && (r_state != S_CLEAR)) |-> (mem_wa != '0))
        else $error("tree walk wrote node zero");

    a_qry_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QRY_R) |-> ((r_cur <= r_rnode) && (r_cur != '0)))
        else $error("query step with crossed or zero bounds");

    a_clear_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CLEAR) && !i_ctl.clear) |=>
            ((r_state == S_IDLE) || (r_clr_cnt == $past(r_clr_cnt) + NW'(1))))
        else $error("clearing pass skipped an entry");

    a_err_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && i_ctl.start && !i_ctl.clear && start_err) |=>
            ((r_state == S_DONE) && r_err))
        else $error("bad index did not go straight to result");
`endif

endmodule

// ----- rtl/range_min_max_segment_tree.sv -----
// ----------------------------------------------------------------------------
// range_min_max_segment_tree: range min/max over a bottom-up segment tree
// An update writes its leaf, then reads the sibling and writes the parent
// up to the root; a query walks both bounds toward the root; a bad index
// goes straight to the result. Next input beat in the cycle after the result
// loads; the walk does one node access per cycle. Reset and each leaf_count
// write clear all 2*MAX_LEAVES nodes, s_axis_tready low; leaf_count -> max.
// ----------------------------------------------------------------------------
module range_min_max_segment_tree #(
    parameter int MAX_LEAVES  = 1024,
    parameter int VALUE_WIDTH = 32,
    localparam int IW    = $clog2(MAX_LEAVES),
    localparam int LW    = $clog2(MAX_LEAVES + 1),
    localparam int IN_W  = ((2 * IW + 2 * VALUE_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((2 * VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LW-1:0]     i_cfg_wdata,     // leaf_count
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,    // left_index, right_index,
                                               // value_min, value_max, zero pad
    input  logic [0:0]        s_axis_tuser,    // action
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,    // result_min, result_max, zero pad
    output logic [0:0]        m_axis_tuser     // index_error
);
    import rmm_pkg::*;

    localparam int VW = VALUE_WIDTH;

    logic [LW-1:0]  r_leaf_count;
    logic           r_out_valid;
    logic [VW-1:0]  r_out_min, r_out_max;
    logic           r_out_err;

    t_eng_ctl       eng_ctl;
    t_eng_sts       eng_sts;
    logic [VW-1:0]  eng_min, eng_max;
    logic           eng_err;
    logic           load_out;

    assign s_axis_tready    = eng_sts.ready;
    assign eng_ctl.start    = s_axis_tvalid && eng_sts.ready;
    assign eng_ctl.clear    = i_cfg_we;
    assign eng_ctl.out_free = !r_out_valid || m_axis_tready;
    assign load_out         = eng_sts.done && eng_ctl.out_free;

    rmm_engine #(
        .MAX_LEAVES  (MAX_LEAVES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (eng_ctl),
        .o_sts         (eng_sts),
        .i_action      (s_axis_tuser[0]),
        .i_left        (s_axis_tdata[IW-1:0]),
        .i_right       (s_axis_tdata[2*IW-1:IW]),
        .i_value_min   (s_axis_tdata[2*IW+VW-1:2*IW]),
        .i_value_max   (s_axis_tdata[2*IW+2*VW-1:2*IW+VW]),
        .i_leaf_count  (r_leaf_count),
        .o_result_min  (eng_min),
        .o_result_max  (eng_max),
        .o_index_error (eng_err)
    );

    // leaf count saturates at the tree size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaf_count <= LW'(MAX_LEAVES);
        end else if (i_cfg_we) begin
            r_leaf_count <= (i_cfg_wdata > LW'(MAX_LEAVES)) ? LW'(MAX_LEAVES)
                                                             : i_cfg_wdata;
        end
    end

    // output register: hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_min <= eng_min;
            r_out_max <= eng_max;
            r_out_err <= eng_err;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = OUT_W'({r_out_max, r_out_min});
    assign m_axis_tuser[0] = r_out_err;

endmodule

// ----- bench/tb_range_min_max_segment_tree.sv -----
// ----------------------------------------------------------------------------
// tb_range_min_max_segment_tree: self-checking bench for the min/max tree
// Drives point updates and range queries over the input stream, mirrors the
// tree in a local predictor and checks every result beat in order. A directed
// table comes first, then random phases at several leaf counts, including
// random gaps on both sides and two long hold-offs on the result side.
// ----------------------------------------------------------------------------
module tb_range_min_max_segment_tree;
    import rmm_pkg::*;

    localparam int LEAVES_MAX   = 1024;
    localparam int NODE_COUNT   = 2 * LEAVES_MAX;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 600;
    localparam int CALM_TAIL    = 60;
    localparam int REPORT_MAX   = 10;
    localparam logic signed [31:0] VAL_TOP = 32'sh7fff_ffff;
    localparam logic signed [31:0] VAL_BOT = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] mn;
        logic signed [31:0] mx;
        logic               err;
    } range_res_t;

    typedef enum int {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic               act;
        int                 lo_idx;
        int                 hi_idx;
        logic signed [31:0] vlo;
        logic signed [31:0] vhi;
        bit                 typed;
        range_res_t         want;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic [10:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [87:0] s_data;
    logic [0:0]  s_user;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_data;
    logic [0:0]  m_user;

    // predictor state
    logic signed [31:0] tree_min [NODE_COUNT];
    logic signed [31:0] tree_max [NODE_COUNT];
    int                 leaf_n;

    range_res_t  pending_q[$];
    stim_row_t   directed_rows[$];

    int  cycle_count  = 0;
    int  fail_count   = 0;
    int  results_seen = 0;
    int  items_sent   = 0;
    int  n_updates    = 0;
    int  n_queries    = 0;
    int  n_flagged    = 0;
    int  n_empty      = 0;
    int  n_cfg        = 0;
    bit  calm         = 1'b0;

    range_min_max_segment_tree dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void clear_tree(input int count);
        leaf_n = (count > LEAVES_MAX) ? LEAVES_MAX : count;
        for (int k = 0; k < NODE_COUNT; k++) begin
            tree_min[k] = VAL_TOP;
            tree_max[k] = VAL_BOT;
        end
    endfunction

    function automatic range_res_t tree_step(input logic act, input int lo_idx,
                                             input int hi_idx,
                                             input logic signed [31:0] vlo,
                                             input logic signed [31:0] vhi);
        range_res_t res;
        int         x;
        int         l;
        int         r;
        res = '0;
        if (act == ACT_UPDATE) begin
            n_updates++;
            if (lo_idx >= leaf_n) begin
                n_flagged++;
                res.err = 1'b1;
                return res;
            end
            x = lo_idx + leaf_n;
            tree_min[x] = vlo;
            tree_max[x] = vhi;
            for (x = x >> 1; x != 0; x = x >> 1) begin
                tree_min[x] = (tree_min[2*x] <= tree_min[2*x+1]) ?
                              tree_min[2*x] : tree_min[2*x+1];
                tree_max[x] = (tree_max[2*x] >= tree_max[2*x+1]) ?
                              tree_max[2*x] : tree_max[2*x+1];
            end
            return res;
        end
        n_queries++;
        if (lo_idx >= leaf_n || hi_idx >= leaf_n) begin
            n_flagged++;
            res.err = 1'b1;
            return res;
        end
        if (lo_idx > hi_idx)
            n_empty++;
        res.mn = VAL_TOP;
        res.mx = VAL_BOT;
        // walk both bounds up, folding in nodes that fall fully inside
        for (l = lo_idx + leaf_n, r = hi_idx + leaf_n; l <= r; l = l >> 1, r = r >> 1) begin
            if (l % 2 == 1) begin
                if (tree_min[l] < res.mn) res.mn = tree_min[l];
                if (tree_max[l] > res.mx) res.mx = tree_max[l];
                l++;
            end
            if (r % 2 == 0) begin
                if (tree_min[r] < res.mn) res.mn = tree_min[r];
                if (tree_max[r] > res.mx) res.mx = tree_max[r];
                r--;
            end
        end
        return res;
    endfunction

    function automatic void add_row(input row_kind_t kind, input logic act,
                                    input int lo_idx, input int hi_idx,
                                    input logic signed [31:0] vlo,
                                    input logic signed [31:0] vhi, input bit typed,
                                    input logic signed [31:0] mn,
                                    input logic signed [31:0] mx, input logic err);
        stim_row_t row;
        row.kind     = kind;
        row.act      = act;
        row.lo_idx   = lo_idx;
        row.hi_idx   = hi_idx;
        row.vlo      = vlo;
        row.vhi      = vhi;
        row.typed    = typed;
        row.want.mn  = mn;
        row.want.mx  = mx;
        row.want.err = err;
        directed_rows.push_back(row);
    endfunction

    function automatic int pick_index(input int count);
        if (count == 0 || $urandom_range(0, 9) == 0)
            return $urandom_range(0, LEAVES_MAX - 1);
        return $urandom_range(0, count - 1);
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return VAL_TOP;
            1:       return VAL_BOT;
            2:       return $signed($urandom_range(0, 40)) - 20;
            default: return $urandom;
        endcase
    endfunction

    // leaf count is written only with nothing in flight
    task automatic set_leaf_count(input int count);
        s_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= 11'(count);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        clear_tree(count);
        n_cfg++;
    endtask

    task automatic send_item(input logic act, input int lo_idx, input int hi_idx,
                             input logic signed [31:0] vlo,
                             input logic signed [31:0] vhi, input bit typed,
                             input range_res_t want);
        range_res_t res;
        s_data  <= {4'b0000, vhi, vlo, 10'(hi_idx), 10'(lo_idx)};
        s_user  <= act;
        s_valid <= 1'b1;
        @(posedge i_clk);
        while (!s_ready)
            @(posedge i_clk);
        res = tree_step(act, lo_idx, hi_idx, vlo, vhi);
        pending_q.push_back(typed ? want : res);
        items_sent++;
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // result side: check beats, random stalls, and two long hold-offs
    initial begin : result_side
        range_res_t got;
        range_res_t want;
        int         stall_cnt;
        bit         held_once;
        bit         held_twice;
        stall_cnt  = 0;
        held_once  = 1'b0;
        held_twice = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_valid && m_ready) begin
                got.mn  = m_data[31:0];
                got.mx  = m_data[63:32];
                got.err = m_user[0];
                results_seen++;
                if (pending_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("unexpected result: min %0d max %0d err %0b",
                                 got.mn, got.mx, got.err);
                end else begin
                    want = pending_q.pop_front();
                    if (got.mn !== want.mn || got.mx !== want.mx ||
                        got.err !== want.err) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display("result %0d: expected min %0d max %0d err %0b, got min %0d max %0d err %0b",
                                     results_seen, want.mn, want.mx, want.err,
                                     got.mn, got.mx, got.err);
                    end
                end
            end
            if (!held_once && results_seen >= 150) begin
                held_once = 1'b1;
                stall_cnt = 300;
            end else if (!held_twice && results_seen >= 420) begin
                held_twice = 1'b1;
                stall_cnt = 250;
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_cnt = $urandom_range(0, 16);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int         phase_leaves[7];
        int         per_phase;
        int         item_no;
        int         swap_idx;
        int         lo_idx;
        int         hi_idx;
        logic       act;
        range_res_t none;
        none = '0;
        i_rst_n   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        s_user    <= '0;
        clear_tree(LEAVES_MAX);

        // empty tree, empty range, value extremes, full and single-leaf spans
        add_row(ROW_ITEM, ACT_QUERY, 0, 1023, 0, 0, 1, VAL_TOP, VAL_BOT, 1'b0);
        add_row(ROW_ITEM, ACT_QUERY, 1023, 0, -1, -1, 1, VAL_TOP, VAL_BOT, 1'b0);
        add_row(ROW_ITEM, ACT_UPDATE, 0, 1023, VAL_BOT, VAL_TOP, 1, 0, 0, 1'b0);
        add_row(ROW_ITEM, ACT_UPDATE, 1023, 555, VAL_TOP, VAL_BOT, 1, 0, 0, 1'b0);
        add_row(ROW_ITEM, ACT_UPDATE, 512, 0, -5, 7, 1, 0, 0, 1'b0);
        add_row(ROW_ITEM, ACT_QUERY, 0, 1023, 0, 0, 0, 0, 0, 1'b0);
        add_row(ROW_ITEM, ACT_QUERY, 1, 1022, 0, 0, 0, 0, 0, 1'b0);
        add_row(ROW_ITEM, ACT_QUERY, 512, 512, 0, 0, 0, 0, 0, 1'b0);
        add_row(ROW_ITEM, ACT_QUERY, 1023, 1023, 0, 0, 0, 0, 0, 1'b0);
        // small tree: out-of-range indexes on either bound
        add_row(ROW_CFG, ACT_UPDATE, 5, 0, 0, 0, 0, 0, 0, 1'b0);
        add_row(ROW_ITEM, ACT_UPDATE, 5, 0, 1, 1, 1, 0, 0, 1'b1);
        add_row(ROW_ITEM, ACT_QUERY, 0, 5, 0, 0, 1, 0, 0, 1'b1);
        add_row(ROW_ITEM, ACT_QUERY, 5, 0, 0, 0, 1, 0, 0, 1'b1);
        add_row(ROW_ITEM, ACT_QUERY, 0, 4, 0, 0, 1, VAL_TOP, VAL_BOT, 1'b0);
        add_row(ROW_ITEM, ACT_UPDATE, 4, 0, -100, 100, 1, 0, 0, 1'b0);
        add_row(ROW_ITEM, ACT_QUERY, 2, 4, 0, 0, 0, 0, 0, 1'b0);
        // zero leaves flags everything
        add_row(ROW_CFG, ACT_UPDATE, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        add_row(ROW_ITEM, ACT_UPDATE, 0, 0, 3, 3, 1, 0, 0, 1'b1);
        add_row(ROW_ITEM, ACT_QUERY, 0, 0, 0, 0, 1, 0, 0, 1'b1);
        // oversized count saturates to the full tree
        add_row(ROW_CFG, ACT_UPDATE, 2047, 0, 0, 0, 0, 0, 0, 1'b0);
        add_row(ROW_ITEM, ACT_UPDATE, 1023, 0, 33, -33, 1, 0, 0, 1'b0);
        add_row(ROW_ITEM, ACT_QUERY, 1022, 1023, 0, 0, 0, 0, 0, 1'b0);
        // single leaf
        add_row(ROW_CFG, ACT_UPDATE, 1, 0, 0, 0, 0, 0, 0, 1'b0);
        add_row(ROW_ITEM, ACT_UPDATE, 0, 0, -7, 9, 1, 0, 0, 1'b0);
        add_row(ROW_ITEM, ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        add_row(ROW_ITEM, ACT_QUERY, 0, 1, 0, 0, 1, 0, 0, 1'b1);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                set_leaf_count(directed_rows[i].lo_idx);
            end else begin
                send_item(directed_rows[i].act, directed_rows[i].lo_idx,
                          directed_rows[i].hi_idx, directed_rows[i].vlo,
                          directed_rows[i].vhi, directed_rows[i].typed,
                          directed_rows[i].want);
                sender_gap();
            end
        end

        phase_leaves = '{1024, 2, 3, 1000, 37, 1, 513};
        per_phase    = (RANDOM_ITEMS + 6) / 7;
        item_no      = 0;
        foreach (phase_leaves[p]) begin
            set_leaf_count(phase_leaves[p]);
            for (int k = 0; k < per_phase; k++) begin
                if (item_no >= RANDOM_ITEMS - CALM_TAIL)
                    calm = 1'b1;
                act    = ($urandom_range(0, 99) < 45) ? ACT_UPDATE : ACT_QUERY;
                lo_idx = pick_index(leaf_n);
                hi_idx = pick_index(leaf_n);
                // keep most query bounds ordered, leave some empty ranges
                if (act == ACT_QUERY && lo_idx > hi_idx && $urandom_range(0, 99) >= 15) begin
                    swap_idx = lo_idx;
                    lo_idx   = hi_idx;
                    hi_idx   = swap_idx;
                end
                send_item(act, lo_idx, hi_idx, pick_value(), pick_value(), 1'b0, none);
                sender_gap();
                item_no++;
            end
        end
        s_valid <= 1'b0;

        while (pending_q.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (pending_q.size() != 0)
            fail_count++;

        $display("sent %0d items (%0d updates, %0d queries), %0d results checked",
                 items_sent, n_updates, n_queries, results_seen);
        $display("%0d flagged indexes, %0d empty ranges, %0d leaf count writes",
                 n_flagged, n_empty, n_cfg);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d failures", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/rmm_pkg.sv
rtl/rmm_engine.sv
rtl/range_min_max_segment_tree.sv
bench/tb_range_min_max_segment_tree.sv
